>>> hw/rtl/bmpw_pkg.sv
// shared types and constants for the bmp24 to lcd window writer
// used by bmpw_res_queue and bmp24_to_lcd_window_writer; no dependencies
`default_nettype none

package bmpw_pkg;

  localparam int unsigned MaxImageWidth = 1280;
  localparam int unsigned MaxResults    = 9;
  localparam int unsigned CntW          = $clog2(MaxResults + 1);

  // result kinds
  localparam logic [1:0] KindCmd    = 2'd0;
  localparam logic [1:0] KindData   = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  // status codes
  localparam logic [15:0] StatAccepted = 16'd0;
  localparam logic [15:0] StatRejected = 16'd1;
  localparam logic [15:0] StatDone     = 16'd2;

  // panel commands
  localparam logic [15:0] CmdColWin  = 16'h0044;
  localparam logic [15:0] CmdRowWin  = 16'h0045;
  localparam logic [15:0] CmdAddr    = 16'h0021;
  localparam logic [15:0] CmdWriteGr = 16'h0022;

  // configuration register indexes
  localparam logic [1:0] RegScreenWidth  = 2'd0;
  localparam logic [1:0] RegScreenHeight = 2'd1;
  localparam logic [1:0] RegColumnOffset = 2'd2;
  localparam logic [1:0] RegRowOffset    = 2'd3;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [15:0] word_value;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
  } res_t;

  typedef struct packed {
    logic            valid;
    logic [CntW-1:0] cnt;
  } load_t;

endpackage

`default_nettype wire

>>> hw/rtl/bmpw_res_queue.sv
// result buffer: holds the results of one byte and hands them out one beat at a time
// depends on bmpw_pkg
`default_nettype none

module bmpw_res_queue (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire bmpw_pkg::load_t                            load_i,
  input  wire bmpw_pkg::res_t [bmpw_pkg::MaxResults-1:0]  res_i,
  output logic                                            free_o,
  output logic                                            out_valid_o,
  input  wire logic                                       out_stall_i,
  output bmpw_pkg::out_item_t                             out_data_o
);

  bmpw_pkg::res_t [bmpw_pkg::MaxResults-1:0] buf_q;
  logic [bmpw_pkg::CntW-1:0] cnt_q, rd_q, rd_inc, rd_idx;
  logic fire;

  assign rd_inc      = rd_q + 1'b1;
  assign out_valid_o = (rd_q != cnt_q);
  assign fire        = out_valid_o & ~out_stall_i;
  assign free_o      = (rd_q == cnt_q) | (fire & (rd_inc == cnt_q));
  assign rd_idx      = (rd_q < bmpw_pkg::CntW'(bmpw_pkg::MaxResults)) ? rd_q : '0;

  always_comb begin
    out_data_o.item_kind   = buf_q[rd_idx].kind;
    out_data_o.word_value  = buf_q[rd_idx].value;
    out_data_o.last_of_run = (rd_inc == cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i.valid) begin
      cnt_q <= load_i.cnt;
      rd_q  <= '0;
    end else if (fire) begin
      rd_q <= rd_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.valid) begin
      buf_q <= res_i;
    end
  end

  a_rd_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) rd_q <= cnt_q)
    else $error("read pointer passed count");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bmpw_pkg::CntW'(bmpw_pkg::MaxResults))
    else $error("count beyond buffer depth");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni) load_i.valid |-> free_o)
    else $error("load over undelivered results");

endmodule

`default_nettype wire

>>> hw/rtl/bmp24_to_lcd_window_writer.sv
// bmp24 file to lcd window writer: an accepted byte passes the input register and then
// the result buffer before its first result beat; one byte per cycle when a byte gives
// at most one result and the output is not stalled; a byte that opens a shown row gives
// 7 beats and holds the input while the result buffer drains one beat per unstalled cycle
// reset (rst_ni low, async) returns to idle awaiting start_of_file and loads the
// default screen size 176 x 220 with zero offsets
`default_nettype none

module bmp24_to_lcd_window_writer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire bmpw_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output bmpw_pkg::out_item_t       out_data_o
);

  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhHeader = 5'b00010,
    PhGap    = 5'b00100,
    PhSkip   = 5'b01000,
    PhRows   = 5'b10000
  } phase_e;

  // configuration registers
  logic [7:0] sw_q, sh_q, co_q, ro_q;

  // input register stage
  logic               iv_q;
  bmpw_pkg::in_item_t ib_q;

  // parse state
  phase_e      phase_q, phase_d, phase_c, ph;
  logic [31:0] pos_q, pos_d, pos_c;
  logic [31:0] po_q, po_d, po_c;
  logic [31:0] w_q, w_d, w_c;
  logic [31:0] h_q, h_d, h_c;
  logic [2:0]  flags_q, flags_d, flags_c;
  logic [7:0]  left_q, left_d, right_q, right_d, top_q, top_d, row_q, row_d;
  logic [31:0] skip_q, skip_d;
  logic [11:0] rbc_q, rbc_d, stride_q, stride_d;
  logic [1:0]  comp_q, comp_d;
  logic [10:0] px_q, px_d;
  logic [15:0] pp_q, pp_d;

  // result assembly
  bmpw_pkg::res_t [bmpw_pkg::MaxResults-1:0] res;
  logic [bmpw_pkg::CntW-1:0] n;
  bmpw_pkg::load_t load;
  logic        free, proc;
  logic [7:0]  b, sw, sh, col_l, col_r, r_addr, dw, dh;
  logic [1:0]  lane;
  logic [31:0] lane_val, start;
  logic        ok, sof;
  logic [8:0]  vis;
  logic [13:0] stride_raw;

  assign proc       = iv_q & free;
  assign in_stall_o = iv_q & ~proc;

  // input register: takes a new byte when empty or when the held byte moves into the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      iv_q <= 1'b1;
    end else if (proc) begin
      iv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ib_q <= in_data_i;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 8'd176;
      sh_q <= 8'd220;
      co_q <= 8'd0;
      ro_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmpw_pkg::RegScreenWidth:  sw_q <= cfg_data_i;
        bmpw_pkg::RegScreenHeight: sh_q <= cfg_data_i;
        bmpw_pkg::RegColumnOffset: co_q <= cfg_data_i;
        bmpw_pkg::RegRowOffset:    ro_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // live address terms for the window commands
  assign col_l  = co_q + left_q;
  assign col_r  = co_q + right_q;
  assign r_addr = ro_q + row_q;
  assign vis    = {1'b0, right_q} - {1'b0, left_q} + 9'd1;
  // zero-sized screen reads as one
  assign sw     = (sw_q == 8'd0) ? 8'd1 : sw_q;
  assign sh     = (sh_q == 8'd0) ? 8'd1 : sh_q;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    po_d     = po_q;
    w_d      = w_q;
    h_d      = h_q;
    flags_d  = flags_q;
    left_d   = left_q;
    right_d  = right_q;
    top_d    = top_q;
    row_d    = row_q;
    skip_d   = skip_q;
    rbc_d    = rbc_q;
    stride_d = stride_q;
    comp_d   = comp_q;
    px_d     = px_q;
    pp_d     = pp_q;
    res      = '0;
    n        = '0;
    b        = ib_q.file_byte;
    sof      = ib_q.start_of_file;
    // a start marker restarts the header parse on this very byte
    phase_c  = sof ? PhHeader : phase_q;
    pos_c    = sof ? 32'd0 : pos_q;
    po_c     = sof ? 32'd0 : po_q;
    w_c      = sof ? 32'd0 : w_q;
    h_c      = sof ? 32'd0 : h_q;
    flags_c  = sof ? 3'd0 : flags_q;
    lane     = 2'(pos_c[1:0] + 2'd2);
    lane_val = 32'(b) << {lane, 3'b000};
    ok       = 1'b0;
    dw       = sw - w_c[7:0];
    dh       = sh - h_c[7:0];
    stride_raw = {2'b0, w_c[11:0]} + {1'b0, w_c[11:0], 1'b0} + 14'd3;
    start    = (po_c < 32'd54) ? 32'd54 : po_c;
    ph       = phase_c;

    if (proc && phase_c != PhIdle) begin
      phase_d = phase_c;
      po_d    = po_c;
      w_d     = w_c;
      h_d     = h_c;
      flags_d = flags_c;
      // byte position saturates at all ones
      pos_d   = (pos_c == 32'hFFFF_FFFF) ? pos_c : pos_c + 32'd1;

      if (phase_c == PhHeader) begin
        // little-endian header fields, one byte lane per position
        if (pos_c >= 32'd10 && pos_c <= 32'd13) po_d = po_c | lane_val;
        if (pos_c >= 32'd18 && pos_c <= 32'd21) w_d  = w_c | lane_val;
        if (pos_c >= 32'd22 && pos_c <= 32'd25) h_d  = h_c | lane_val;
        if (pos_c == 32'd26 && b != 8'd1)  flags_d[0] = 1'b1;
        if (pos_c == 32'd27 && b != 8'd0)  flags_d[0] = 1'b1;
        if (pos_c == 32'd28 && b != 8'd24) flags_d[1] = 1'b1;
        if (pos_c == 32'd29 && b != 8'd0)  flags_d[1] = 1'b1;
        if (pos_c >= 32'd30 && pos_c <= 32'd33 && b != 8'd0) flags_d[2] = 1'b1;

        if (pos_c == 32'd33) begin
          ok = (flags_d == 3'd0) && (w_d != 32'd0) &&
               (w_d <= 32'(bmpw_pkg::MaxImageWidth)) && (h_d != 32'd0);
          res[n] = '{kind: bmpw_pkg::KindStatus,
                     value: ok ? bmpw_pkg::StatAccepted : bmpw_pkg::StatRejected};
          n = n + 1'b1;
          if (!ok) begin
            phase_d = PhIdle;
          end else begin
            // center or crop to the left columns
            if (w_d > {24'd0, sw}) begin
              left_d  = 8'd0;
              right_d = sw - 8'd1;
            end else begin
              left_d  = {1'b0, dw[7:1]};
              right_d = {1'b0, dw[7:1]} + w_d[7:0] - 8'd1;
            end
            // center or crop to the top rows, dropping bottom file rows
            if (h_d > {24'd0, sh}) begin
              top_d  = 8'd0;
              row_d  = sh - 8'd1;
              skip_d = h_d - {24'd0, sh};
            end else begin
              top_d  = {1'b0, dh[7:1]};
              row_d  = {1'b0, dh[7:1]} + h_d[7:0] - 8'd1;
              skip_d = 32'd0;
            end
            stride_d = stride_raw[11:0] & 12'hFFC;
            rbc_d    = 12'd0;
            comp_d   = 2'd0;
            px_d     = 11'd0;
            phase_d  = PhGap;
          end
        end
      end else begin
        if (phase_c == PhGap && pos_c >= start) begin
          ph = (skip_q != 32'd0) ? PhSkip : PhRows;
        end
        phase_d = ph;

        if (ph == PhSkip) begin
          if ({1'b0, rbc_q} + 13'd1 >= {1'b0, stride_q}) begin
            rbc_d  = 12'd0;
            skip_d = skip_q - 32'd1;
            if (skip_d == 32'd0) phase_d = PhRows;
          end else begin
            rbc_d = rbc_q + 12'd1;
          end
        end else if (ph == PhRows) begin
          if (rbc_q == 12'd0) begin
            res[0] = '{kind: bmpw_pkg::KindCmd,  value: bmpw_pkg::CmdColWin};
            res[1] = '{kind: bmpw_pkg::KindData, value: {col_r, col_l}};
            res[2] = '{kind: bmpw_pkg::KindCmd,  value: bmpw_pkg::CmdRowWin};
            res[3] = '{kind: bmpw_pkg::KindData, value: {r_addr, r_addr}};
            res[4] = '{kind: bmpw_pkg::KindCmd,  value: bmpw_pkg::CmdAddr};
            res[5] = '{kind: bmpw_pkg::KindData, value: {r_addr, col_l}};
            res[6] = '{kind: bmpw_pkg::KindCmd,  value: bmpw_pkg::CmdWriteGr};
            n = bmpw_pkg::CntW'(7);
          end
          // b, g, r order; pixel word goes out on the red byte
          if (px_q < {2'b0, vis}) begin
            unique case (comp_q)
              2'd0: pp_d = {11'd0, b[7:3]};
              2'd1: pp_d = pp_q | {5'd0, b[7:2], 5'd0};
              default: begin
                pp_d = pp_q | {b[7:3], 11'd0};
                res[n] = '{kind: bmpw_pkg::KindData, value: pp_d};
                n = n + 1'b1;
              end
            endcase
          end
          comp_d = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
          px_d   = (comp_q == 2'd2) ? px_q + 11'd1 : px_q;
          if ({1'b0, rbc_q} + 13'd1 >= {1'b0, stride_q}) begin
            rbc_d  = 12'd0;
            comp_d = 2'd0;
            px_d   = 11'd0;
            if (row_q == top_q) begin
              res[n] = '{kind: bmpw_pkg::KindStatus, value: bmpw_pkg::StatDone};
              n = n + 1'b1;
              phase_d = PhIdle;
            end else begin
              row_d = row_q - 8'd1;
            end
          end else begin
            rbc_d = rbc_q + 12'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pos_q   <= '0;
      po_q    <= '0;
      w_q     <= '0;
      h_q     <= '0;
      flags_q <= '0;
      left_q  <= '0;
      right_q <= '0;
      top_q   <= '0;
      row_q   <= '0;
      skip_q  <= '0;
      rbc_q   <= '0;
      stride_q <= '0;
      comp_q  <= '0;
      px_q    <= '0;
      pp_q    <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      po_q    <= po_d;
      w_q     <= w_d;
      h_q     <= h_d;
      flags_q <= flags_d;
      left_q  <= left_d;
      right_q <= right_d;
      top_q   <= top_d;
      row_q   <= row_d;
      skip_q  <= skip_d;
      rbc_q   <= rbc_d;
      stride_q <= stride_d;
      comp_q  <= comp_d;
      px_q    <= px_d;
      pp_q    <= pp_d;
    end
  end

  assign load.valid = proc;
  assign load.cnt   = n;

  // result buffer drains one beat per cycle while the output is not stalled
  bmpw_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> iv_q)
    else $error("input stalled with empty input register");
  a_row_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhRows) |-> (row_q >= top_q))
    else $error("screen row above window top");
  a_rbc_in_stride: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhRows || phase_q == PhSkip) |-> (rbc_q < stride_q))
    else $error("row byte count beyond stride");

endmodule

`default_nettype wire
